FILE: sv/r2h_pkg.sv
// Types, constants and divider step functions for the RGB to HSV pipeline.
package r2h_pkg;

	// Hue scale and sector offsets (full circle = 256)
	localparam logic [5:0] HUE_STEP     = 6'd43;
	localparam logic [7:0] RED_OFFSET   = 8'd0;
	localparam logic [7:0] GREEN_OFFSET = 8'd85;
	localparam logic [7:0] BLUE_OFFSET  = 8'd171;

	// Input item: one RGB pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Result item: one HSV triple
	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	// Divider state carried through the pipeline
	typedef struct packed {
		logic [7:0] sat_rem;     // partial remainder, saturation divide
		logic [7:0] sat_num;     // numerator bits still to shift in
		logic [7:0] sat_quo;     // saturation quotient bits so far
		logic [7:0] sat_den;     // divisor: brightness
		logic [7:0] hue_rem;     // partial remainder, hue divide
		logic [5:0] hue_num;
		logic [5:0] hue_quo;
		logic [7:0] hue_den;     // divisor: max - min
		logic       hue_neg;     // channel difference was negative
		logic [7:0] hue_off;     // sector offset
		logic       grey;        // max equals min: hue and saturation are zero
	} div_t;

	// One restoring step result
	typedef struct packed {
		logic [7:0] rem;
		logic       qbit;
	} step_t;

	// Restoring divide step: shift one numerator bit in, subtract if it fits
	function automatic step_t div_step(input logic [7:0] rem, input logic nbit,
		input logic [7:0] den);
		logic [8:0] trial;
		logic [8:0] diff;
		step_t      res;
		trial = {rem, nbit};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			res.rem  = diff[7:0];
			res.qbit = 1'b1;
		end else begin
			res.rem  = trial[7:0];
			res.qbit = 1'b0;
		end
		return res;
	endfunction

	// Two divider iterations; the hue divide only runs while do_hue is set
	function automatic div_t div_pass(input div_t st, input logic do_hue);
		div_t  nx;
		step_t s;
		nx = st;
		for (int k = 0; k < 2; k++) begin
			s          = div_step(nx.sat_rem, nx.sat_num[7], nx.sat_den);
			nx.sat_rem = s.rem;
			nx.sat_num = {nx.sat_num[6:0], 1'b0};
			nx.sat_quo = {nx.sat_quo[6:0], s.qbit};
			if (do_hue) begin
				s          = div_step(nx.hue_rem, nx.hue_num[5], nx.hue_den);
				nx.hue_rem = s.rem;
				nx.hue_num = {nx.hue_num[4:0], 1'b0};
				nx.hue_quo = {nx.hue_quo[4:0], s.qbit};
			end
		end
		return nx;
	endfunction

endpackage

FILE: sv/rgb_to_hsv_8bit_core.sv
// RGB to HSV converter, seven-stage pipeline with two pipelined dividers.
// Throughput: one pixel per cycle; the divides run two quotient bits per stage,
// saturation over four stages and hue over three, and the whole pipe holds
// while the output stalls.
// Reset: arst_n clears all valid bits asynchronously; payload is not reset.
module rgb_to_hsv_8bit_core
	import r2h_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pixel_valid,
	output logic pixel_stall,
	input  rgb_t pixel,
	output logic hsv_valid,
	input  logic hsv_stall,
	output hsv_t hsv
);

	// Stage registers
	logic [7:0] hi_s1, span_s1, mag_s1, off_s1;
	logic       neg_s1;
	div_t       div_s2, div_s3, div_s4, div_s5, div_s6;
	logic [6:0] valid_q;
	logic       advance;

	// Stage 1 combinational: max, min, sector and channel difference
	logic [7:0] hi_c, lo_c, off_c;
	logic [8:0] diff_c;

	// Stage 2 combinational: numerators
	logic [15:0] sat_num_c;
	logic [13:0] hue_num_c;

	// Output stage combinational
	logic [7:0] hue_part_c;

	// Whole pipe moves unless a result is held at the output
	assign advance     = !(hsv_valid && hsv_stall);
	assign pixel_stall = !advance;
	assign hsv_valid   = valid_q[6];

	always_comb begin
		hi_c = (pixel.red > pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue > hi_c) hi_c = pixel.blue;
		lo_c = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue < lo_c) lo_c = pixel.blue;
		// Red wins ties, then green
		if (hi_c == pixel.red) begin
			off_c  = RED_OFFSET;
			diff_c = {1'b0, pixel.green} - {1'b0, pixel.blue};
		end else if (hi_c == pixel.green) begin
			off_c  = GREEN_OFFSET;
			diff_c = {1'b0, pixel.blue} - {1'b0, pixel.red};
		end else begin
			off_c  = BLUE_OFFSET;
			diff_c = {1'b0, pixel.red} - {1'b0, pixel.green};
		end
	end

	// 255*span and 43*|diff|
	assign sat_num_c = {span_s1, 8'h00} - {8'h00, span_s1};
	assign hue_num_c = 14'(HUE_STEP) * 14'(mag_s1);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[5:0], pixel_valid};
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (advance) begin
			// s1
			hi_s1   <= hi_c;
			span_s1 <= hi_c - lo_c;
			off_s1  <= off_c;
			neg_s1  <= diff_c[8];
			mag_s1  <= diff_c[8] ? 8'(-diff_c) : diff_c[7:0];
			// s2: quotients fit in 8 and 6 bits, so the top numerator bits
			// seed the remainders directly
			div_s2.sat_rem <= sat_num_c[15:8];
			div_s2.sat_num <= sat_num_c[7:0];
			div_s2.sat_quo <= '0;
			div_s2.sat_den <= hi_s1;
			div_s2.hue_rem <= hue_num_c[13:6];
			div_s2.hue_num <= hue_num_c[5:0];
			div_s2.hue_quo <= '0;
			div_s2.hue_den <= span_s1;
			div_s2.hue_neg <= neg_s1;
			div_s2.hue_off <= off_s1;
			div_s2.grey    <= (span_s1 == 8'd0);
			// s3..s6: two divide iterations each
			div_s3 <= div_pass(div_s2, 1'b1);
			div_s4 <= div_pass(div_s3, 1'b1);
			div_s5 <= div_pass(div_s4, 1'b1);
			div_s6 <= div_pass(div_s5, 1'b0);
			// s7: output register
			hsv.brightness <= div_s6.sat_den;
			hsv.saturation <= div_s6.grey ? 8'd0 : div_s6.sat_quo;
			hsv.hue        <= div_s6.grey ? 8'd0 : div_s6.hue_off + hue_part_c;
		end
	end

	// Signed hue part, truncated toward zero
	always_comb begin
		hue_part_c = {2'b00, div_s6.hue_quo};
		if (div_s6.hue_neg) hue_part_c = 8'(-hue_part_c);
	end

	// Grey or black pixels carry no hue
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.saturation == 8'd0) |-> (hsv.hue == 8'd0))
		else $error("hue nonzero with zero saturation");

	// Black pixels carry no saturation
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.brightness == 8'd0) |-> (hsv.saturation == 8'd0))
		else $error("saturation nonzero for black pixel");

	// An accepted pixel reaches the first stage
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> valid_q[0])
		else $error("accepted pixel lost at stage one");

endmodule
